// ===== design/trpg_pkg.sv =====
package trpg_pkg;

	// Default geometry of the panel and the line buffer
	localparam int PANEL_WIDTH_DEF = 128;
	localparam int LINE_CHARS_DEF  = 32;

	// Field widths
	localparam int CODE_W  = 8;
	localparam int POS_W   = 5;
	localparam int COLOR_W = 16;
	localparam int LEN_W   = 7;
	localparam int CFG_W   = 8;

	// Font geometry
	localparam int FONT_COUNT  = 48;
	localparam int DOT_COLS    = 5;
	localparam logic [5:0] QMARK_INDEX = 6'd14;

	// Reciprocals scaled by 2**RECIP_SHIFT, rounded up; exact for numerators below 1170
	localparam int RECIP_SHIFT = 13;
	localparam int RECIP_W     = 14;
	localparam int SIX_W       = 11;
	localparam logic [SIX_W-1:0] RECIP_SIX = 11'd1366;

	localparam logic [COLOR_W-1:0] COLOR_BLACK = 16'h0000;

	typedef enum logic {
		KIND_LOAD = 1'b0,
		KIND_TICK = 1'b1
	} item_kind_t;

	typedef enum logic [1:0] {
		CFG_GLYPH_SCALE = 2'd0,
		CFG_BAND_HEIGHT = 2'd1,
		CFG_TEXT_LENGTH = 2'd2,
		CFG_ROW_TONE    = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_CALC = 2'd1,
		ST_EMIT = 2'd2
	} ctrl_state_t;

	typedef struct packed {
		logic              kind;
		logic [POS_W-1:0]  char_position;
		logic [CODE_W-1:0] char_code;
	} in_item_t;

	typedef struct packed {
		logic [COLOR_W-1:0] pixel_color;
		logic               band_last;
	} out_item_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic tick;  // pixel beat taken: capture stage 1, advance counters
		logic load;  // load beat taken: write the line buffer
		logic calc;  // stage 2: split column, read line buffer
		logic emit;  // stage 3: load the output register
	} trpg_cmd_t;

	localparam logic [CODE_W-1:0] FONT_CHARS [FONT_COUNT] = '{
		8'h20, 8'h2D, 8'h2E, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34,
		8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h3A, 8'h3F, 8'h41,
		8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49,
		8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51,
		8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59,
		8'h5A, 8'h62, 8'h64, 8'h6B, 8'h6D, 8'h70, 8'h73, 8'h7A
	};

	// One byte per dot column, bit 0 at the top row
	localparam logic [7:0] FONT_DOTS [FONT_COUNT][DOT_COLS] = '{
		'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08},
		'{8'h00, 8'h00, 8'h60, 8'h60, 8'h00}, '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E},
		'{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00}, '{8'h72, 8'h49, 8'h49, 8'h49, 8'h46},
		'{8'h21, 8'h41, 8'h49, 8'h4D, 8'h33}, '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10},
		'{8'h27, 8'h45, 8'h45, 8'h45, 8'h39}, '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h31},
		'{8'h41, 8'h21, 8'h11, 8'h09, 8'h07}, '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36},
		'{8'h46, 8'h49, 8'h49, 8'h29, 8'h1E}, '{8'h00, 8'h00, 8'h14, 8'h00, 8'h00},
		'{8'h02, 8'h01, 8'h59, 8'h09, 8'h06}, '{8'h7C, 8'h12, 8'h11, 8'h12, 8'h7C},
		'{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22},
		'{8'h7F, 8'h41, 8'h41, 8'h41, 8'h3E}, '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41},
		'{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01}, '{8'h3E, 8'h41, 8'h41, 8'h51, 8'h73},
		'{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F}, '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00},
		'{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01}, '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41},
		'{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40}, '{8'h7F, 8'h02, 8'h1C, 8'h02, 8'h7F},
		'{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F}, '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E},
		'{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06}, '{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E},
		'{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46}, '{8'h26, 8'h49, 8'h49, 8'h49, 8'h32},
		'{8'h03, 8'h01, 8'h7F, 8'h01, 8'h03}, '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F},
		'{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F}, '{8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F},
		'{8'h63, 8'h14, 8'h08, 8'h14, 8'h63}, '{8'h03, 8'h04, 8'h78, 8'h04, 8'h03},
		'{8'h61, 8'h59, 8'h49, 8'h4D, 8'h43}, '{8'h7F, 8'h28, 8'h44, 8'h44, 8'h38},
		'{8'h38, 8'h44, 8'h44, 8'h28, 8'h7F}, '{8'h7F, 8'h10, 8'h28, 8'h44, 8'h00},
		'{8'h7C, 8'h04, 8'h78, 8'h04, 8'h78}, '{8'hFC, 8'h18, 8'h24, 8'h24, 8'h18},
		'{8'h48, 8'h54, 8'h54, 8'h54, 8'h24}, '{8'h44, 8'h64, 8'h54, 8'h4C, 8'h44}
	};

	// Tones: white, cyan, green, yellow, red, grey; unused codes give white
	localparam logic [COLOR_W-1:0] TONE_PALETTE [8] = '{
		16'hFFFF, 16'h07FF, 16'h07E0, 16'hFFE0, 16'hF800, 16'h8410, 16'hFFFF, 16'hFFFF
	};

	// Map a character byte to its glyph, '?' when the byte is not in the font
	function automatic logic [5:0] font_index(input logic [CODE_W-1:0] code);
		logic [5:0] idx;
		idx = QMARK_INDEX;
		for (int i = 0; i < FONT_COUNT; i++) begin
			if (code == FONT_CHARS[i]) begin
				idx = 6'(i);
			end
		end
		return idx;
	endfunction

	// Rounded-up reciprocal of the dot scale
	function automatic logic [RECIP_W-1:0] scale_recip(input logic [2:0] scale);
		logic [RECIP_W-1:0] r;
		case (scale)
			3'd2:    r = 14'd4096;
			3'd3:    r = 14'd2731;
			3'd4:    r = 14'd2048;
			3'd5:    r = 14'd1639;
			3'd6:    r = 14'd1366;
			3'd7:    r = 14'd1171;
			default: r = 14'd8192;
		endcase
		return r;
	endfunction

endpackage

// ===== design/trpg_ram.sv =====
module trpg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/trpg_ctrl.sv =====
module trpg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_kind,
	output logic                in_ready,
	input  logic                out_ready,
	output logic                out_valid,
	output trpg_pkg::trpg_cmd_t cmd
);

	trpg_pkg::ctrl_state_t state_q, state_d;
	logic                  out_valid_q;
	logic                  out_free;

	// Output register may take a new beat when empty or being drained
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= trpg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			trpg_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_kind == trpg_pkg::KIND_TICK) begin
						cmd.tick = 1'b1;
						state_d  = trpg_pkg::ST_CALC;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			trpg_pkg::ST_CALC: begin
				cmd.calc = 1'b1;
				state_d  = trpg_pkg::ST_EMIT;
			end
			trpg_pkg::ST_EMIT: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					in_ready = 1'b1;
					state_d  = trpg_pkg::ST_IDLE;
					if (in_valid) begin
						if (in_kind == trpg_pkg::KIND_TICK) begin
							cmd.tick = 1'b1;
							state_d  = trpg_pkg::ST_CALC;
						end else begin
							cmd.load = 1'b1;
						end
					end
				end
			end
			default: begin
				state_d = trpg_pkg::ST_IDLE;
			end
		endcase
	end

	// Output valid: set on emit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== design/trpg_datapath.sv =====
module trpg_datapath #(
	parameter int PANEL_WIDTH = trpg_pkg::PANEL_WIDTH_DEF,
	parameter int LINE_CHARS  = trpg_pkg::LINE_CHARS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  trpg_pkg::trpg_cmd_t              cmd,
	input  logic                             cfg_valid,
	input  logic [1:0]                       cfg_index,
	input  logic [trpg_pkg::CFG_W-1:0]       cfg_data,
	input  trpg_pkg::in_item_t               in_data,
	output trpg_pkg::out_item_t              out_data
);

	localparam int COL_W = $clog2(PANEL_WIDTH);
	localparam int CI_W  = COL_W - 2;
	localparam int AW    = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;
	localparam int CMP_W = (CI_W > trpg_pkg::LEN_W) ? CI_W : trpg_pkg::LEN_W;
	localparam int K     = trpg_pkg::RECIP_SHIFT;
	localparam int RP_W  = COL_W + trpg_pkg::RECIP_W;
	localparam int SP_W  = COL_W + trpg_pkg::SIX_W;
	localparam int FP_W  = 6 + trpg_pkg::RECIP_W;

	// Configuration registers
	logic [2:0] scale_q;
	logic [7:0] height_q;
	logic [5:0] length_q;
	logic [2:0] tone_q;

	// Raster counters
	logic [7:0]       row_q;
	logic [COL_W-1:0] col_q;

	// Front end
	logic [2:0]                   scale;
	logic [7:0]                   height;
	logic [5:0]                   glyph_h;
	logic [6:0]                   top;
	logic [1:0]                   left;
	logic [7:0]                   row_w;
	logic [8:0]                   y_end;
	logic                         in_y;
	logic                         in_x;
	logic [5:0]                   ry;
	logic [COL_W-1:0]             rel;
	logic [trpg_pkg::RECIP_W-1:0] recip;
	logic [RP_W-1:0]              rel_prod;
	logic                         col_last;
	logic                         band_last;

	// Stage 1
	logic [COL_W-1:0] q1_s1;
	logic             vis_s1;
	logic [5:0]       ry_s1;
	logic             last_s1;

	// Stage 2
	logic [SP_W-1:0]            ci_prod;
	logic [CI_W-1:0]            ci;
	logic [COL_W-1:0]           fx_full;
	logic [2:0]                 fx;
	logic [trpg_pkg::LEN_W-1:0] len;
	logic                       in_text;
	logic [FP_W-1:0]            fy_prod;
	logic [2:0]                 fy;
	logic                       vis_s2;
	logic [2:0]                 fx_s2;
	logic [2:0]                 fy_s2;
	logic                       last_s2;

	// Stage 3
	logic [trpg_pkg::CODE_W-1:0]  rd_code;
	logic [5:0]                   glyph_idx;
	logic [2:0]                   fx_sel;
	logic [7:0]                   dot_col;
	logic [trpg_pkg::COLOR_W-1:0] color;
	logic                         buf_we;
	trpg_pkg::out_item_t          out_data_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= 3'd3;
			height_q <= 8'd36;
			length_q <= 6'd0;
			tone_q   <= 3'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				trpg_pkg::CFG_GLYPH_SCALE: scale_q  <= cfg_data[2:0];
				trpg_pkg::CFG_BAND_HEIGHT: height_q <= cfg_data;
				trpg_pkg::CFG_TEXT_LENGTH: length_q <= cfg_data[5:0];
				trpg_pkg::CFG_ROW_TONE:    tone_q   <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// Band geometry and position of the pending pixel
	always_comb begin
		scale    = (scale_q == 3'd0) ? 3'd1 : scale_q;
		height   = (height_q == 8'd0) ? 8'd1 : height_q;
		glyph_h  = {scale, 3'b000};
		top      = (height >= {2'b00, glyph_h}) ? 7'((height - {2'b00, glyph_h}) >> 1) : 7'd0;
		left     = (scale == 3'd3) ? 2'd1 : 2'd2;
		row_w    = (row_q >= height) ? 8'd0 : row_q;
		y_end    = {2'b00, top} + {3'b000, glyph_h};
		in_y     = ({1'b0, row_w} >= {2'b00, top}) && ({1'b0, row_w} < y_end);
		ry       = 6'(row_w - {1'b0, top});
		in_x     = col_q >= COL_W'(left);
		rel      = col_q - COL_W'(left);
		recip    = trpg_pkg::scale_recip(scale);
		rel_prod = RP_W'(rel) * RP_W'(recip);
		col_last = col_q == COL_W'(PANEL_WIDTH - 1);
		band_last = col_last && (row_w == height - 8'd1);
	end

	// Advance the raster counters on a pixel beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= 8'd0;
			col_q <= '0;
		end else if (cmd.tick) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= band_last ? 8'd0 : row_w + 8'd1;
			end else begin
				col_q <= col_q + COL_W'(1);
				row_q <= row_w;
			end
		end
	end

	// Stage 1: dot column across the line
	always_ff @(posedge clk) begin
		if (cmd.tick) begin
			q1_s1   <= rel_prod[K+COL_W-1:K];
			vis_s1  <= in_x && in_y;
			ry_s1   <= ry;
			last_s1 <= band_last;
		end
	end

	// Stage 2: character slot, dot column in the cell, dot row
	always_comb begin
		ci_prod = SP_W'(q1_s1) * SP_W'(trpg_pkg::RECIP_SIX);
		ci      = ci_prod[K+CI_W-1:K];
		fx_full = q1_s1 - COL_W'({ci, 2'b00}) - COL_W'({ci, 1'b0});
		fx      = fx_full[2:0];
		len     = ({1'b0, length_q} > trpg_pkg::LEN_W'(LINE_CHARS)) ?
			trpg_pkg::LEN_W'(LINE_CHARS) : {1'b0, length_q};
		in_text = CMP_W'(ci) < CMP_W'(len);
		fy_prod = FP_W'(ry_s1) * FP_W'(recip);
		fy      = fy_prod[K+2:K];
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			vis_s2  <= vis_s1 && in_text && (fx != 3'(trpg_pkg::DOT_COLS));
			fx_s2   <= fx;
			fy_s2   <= fy;
			last_s2 <= last_s1;
		end
	end

	// Line buffer; loads beyond the last slot are dropped
	assign buf_we = cmd.load &&
		({2'b00, in_data.char_position} < trpg_pkg::LEN_W'(LINE_CHARS));

	trpg_ram #(
		.WIDTH(trpg_pkg::CODE_W),
		.DEPTH(LINE_CHARS)
	) u_line_buf (
		.clk  (clk),
		.we   (buf_we),
		.waddr(AW'(in_data.char_position)),
		.wdata(in_data.char_code),
		.re   (cmd.calc),
		.raddr(AW'(ci)),
		.rdata(rd_code)
	);

	// Stage 3: glyph lookup and colour
	always_comb begin
		glyph_idx = trpg_pkg::font_index(rd_code);
		fx_sel    = (fx_s2 < 3'(trpg_pkg::DOT_COLS)) ? fx_s2 : 3'd0;
		dot_col   = trpg_pkg::FONT_DOTS[glyph_idx][fx_sel];
		color     = (vis_s2 && dot_col[fy_s2]) ? trpg_pkg::TONE_PALETTE[tone_q] :
			trpg_pkg::COLOR_BLACK;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q.pixel_color <= color;
			out_data_q.band_last   <= last_s2;
		end
	end

	assign out_data = out_data_q;

endmodule

// ===== design/text_row_pixel_generator.sv =====
// Text band pixel generator: draws one band of 5x8 text on an RGB565 panel.
// Input channel (in_valid/in_ready/in_data): a load beat writes char_code
// into line buffer slot char_position and gives no result; a tick beat
// asks for the next pixel in raster order, column fastest.
// Output channel (out_valid/out_ready/out_data): one beat per tick with the
// pixel colour; band_last marks the final pixel, then the raster restarts.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): scale,
// band height, text length and tone; always ready; write only while idle (not enforced by the block).
// Path: a tick fills stage 1, then stage 2, then the output register once it is free.
// Loads: one per cycle while in_ready is high. A pixel walks
// three steps (column split by reciprocal multiply, line buffer read with
// its registered port, glyph lookup); the next tick is taken in the third.
// Stalls: the output register holds its beat while out_ready is low; one
// further pixel waits finished in the datapath, then in_ready drops.
// Reset: scale 3, height 36, no text, white tone, raster at row 0, column 0;
// the line buffer holds nothing until written.
module text_row_pixel_generator #(
	parameter int PANEL_WIDTH = trpg_pkg::PANEL_WIDTH_DEF,
	parameter int LINE_CHARS  = trpg_pkg::LINE_CHARS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  trpg_pkg::in_item_t         in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output trpg_pkg::out_item_t        out_data,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [trpg_pkg::CFG_W-1:0] cfg_data
);

	trpg_pkg::trpg_cmd_t cmd;

	// Registers are always writable
	assign cfg_ready = 1'b1;

	trpg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_kind  (in_data.kind),
		.in_ready (in_ready),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.cmd      (cmd)
	);

	trpg_datapath #(
		.PANEL_WIDTH(PANEL_WIDTH),
		.LINE_CHARS (LINE_CHARS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_data  (in_data),
		.out_data (out_data)
	);

endmodule

// ===== design/trpg_checker.sv =====
module trpg_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input trpg_pkg::in_item_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input trpg_pkg::out_item_t out_data
);

	logic tick_beat;

	assign tick_beat = in_valid && in_ready && (in_data.kind == trpg_pkg::KIND_TICK);

	// Hold a stalled output beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	// Fresh output only after a matching pixel tick
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(tick_beat, 3))
		else $error("output beat without a matching tick");

	// No beat taken straight after a tick
	a_tick_gap: assert property (@(posedge clk) disable iff (!arst_n)
		tick_beat |=> !(in_valid && in_ready))
		else $error("input taken while a pixel is being worked out");

endmodule

bind text_row_pixel_generator trpg_checker u_trpg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.in_data  (in_data),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);

// ===== test/text_row_pixel_checker.sv =====
`timescale 1ns / 100ps

module text_row_pixel_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  trpg_pkg::in_item_t         in_data,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  trpg_pkg::out_item_t        out_data,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [trpg_pkg::CFG_W-1:0] cfg_data,
	output int                         fail_count,
	output int                         pending
);

	localparam int PANEL_COLS    = 128;
	localparam int BUF_SLOTS     = 32;
	localparam int GLYPHS        = 48;
	localparam int UNKNOWN_GLYPH = 14;

	localparam logic [15:0] COLOUR_OFF = 16'h0000;

	localparam logic [8*GLYPHS-1:0] GLYPH_SET =
		" -.0123456789:?ABCDEFGHIJKLMNOPQRSTUVWXYZbdkmpsz";

	// Dot columns per glyph, bit 0 is the top dot row
	localparam logic [7:0] GLYPH_COLS [GLYPHS][5] = '{
		'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08},
		'{8'h00, 8'h00, 8'h60, 8'h60, 8'h00}, '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E},
		'{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00}, '{8'h72, 8'h49, 8'h49, 8'h49, 8'h46},
		'{8'h21, 8'h41, 8'h49, 8'h4D, 8'h33}, '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10},
		'{8'h27, 8'h45, 8'h45, 8'h45, 8'h39}, '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h31},
		'{8'h41, 8'h21, 8'h11, 8'h09, 8'h07}, '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36},
		'{8'h46, 8'h49, 8'h49, 8'h29, 8'h1E}, '{8'h00, 8'h00, 8'h14, 8'h00, 8'h00},
		'{8'h02, 8'h01, 8'h59, 8'h09, 8'h06}, '{8'h7C, 8'h12, 8'h11, 8'h12, 8'h7C},
		'{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22},
		'{8'h7F, 8'h41, 8'h41, 8'h41, 8'h3E}, '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41},
		'{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01}, '{8'h3E, 8'h41, 8'h41, 8'h51, 8'h73},
		'{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F}, '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00},
		'{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01}, '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41},
		'{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40}, '{8'h7F, 8'h02, 8'h1C, 8'h02, 8'h7F},
		'{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F}, '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E},
		'{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06}, '{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E},
		'{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46}, '{8'h26, 8'h49, 8'h49, 8'h49, 8'h32},
		'{8'h03, 8'h01, 8'h7F, 8'h01, 8'h03}, '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F},
		'{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F}, '{8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F},
		'{8'h63, 8'h14, 8'h08, 8'h14, 8'h63}, '{8'h03, 8'h04, 8'h78, 8'h04, 8'h03},
		'{8'h61, 8'h59, 8'h49, 8'h4D, 8'h43}, '{8'h7F, 8'h28, 8'h44, 8'h44, 8'h38},
		'{8'h38, 8'h44, 8'h44, 8'h28, 8'h7F}, '{8'h7F, 8'h10, 8'h28, 8'h44, 8'h00},
		'{8'h7C, 8'h04, 8'h78, 8'h04, 8'h78}, '{8'hFC, 8'h18, 8'h24, 8'h24, 8'h18},
		'{8'h48, 8'h54, 8'h54, 8'h54, 8'h24}, '{8'h44, 8'h64, 8'h54, 8'h4C, 8'h44}
	};

	// White, cyan, green, yellow, red, grey; the two spare codes give white
	localparam logic [15:0] TONE_COLOURS [8] = '{
		16'hFFFF, 16'h07FF, 16'h07E0, 16'hFFE0, 16'hF800, 16'h8410, 16'hFFFF, 16'hFFFF
	};

	logic [2:0]            dot_scale;
	logic [7:0]            band_rows;
	logic [5:0]            text_chars;
	logic [2:0]            tone;
	logic [7:0]            line_chars [BUF_SLOTS];
	int unsigned           raster_row;
	int unsigned           raster_col;
	trpg_pkg::out_item_t   expected_pixels [$];
	trpg_pkg::out_item_t   want;

	// Glyph slot of a character byte, question mark when the byte has no glyph
	function automatic int glyph_of(logic [7:0] code);
		int g;
		g = UNKNOWN_GLYPH;
		for (int i = 0; i < GLYPHS; i++) begin
			if (GLYPH_SET[8*(GLYPHS-1-i) +: 8] == code) begin
				g = i;
			end
		end
		return g;
	endfunction

	// Colour of one raster position under the current settings
	function automatic logic [15:0] pixel_colour(int unsigned r, int unsigned c);
		int unsigned sc, rows_eff, gh, top, left, len, rel, ci, cx;
		logic [7:0] dots;
		sc       = (dot_scale == 0) ? 1 : dot_scale;
		rows_eff = (band_rows == 0) ? 1 : band_rows;
		gh       = 8 * sc;
		top      = (rows_eff >= gh) ? (rows_eff - gh) / 2 : 0;
		left     = (sc == 3) ? 1 : 2;
		len      = (text_chars > BUF_SLOTS) ? BUF_SLOTS : text_chars;
		if (r < top || r >= top + gh || c < left) begin
			return COLOUR_OFF;
		end
		rel = c - left;
		ci  = rel / (6 * sc);
		cx  = rel % (6 * sc);
		if (ci >= len || cx >= 5 * sc) begin
			return COLOUR_OFF;
		end
		dots = GLYPH_COLS[glyph_of(line_chars[ci])][cx / sc];
		return dots[(r - top) / sc] ? TONE_COLOURS[tone] : COLOUR_OFF;
	endfunction

	// Queue the pixel for the current raster position, then advance
	task automatic predict_tick();
		int unsigned         rows_eff;
		trpg_pkg::out_item_t beat;
		rows_eff = (band_rows == 0) ? 1 : band_rows;
		if (raster_row >= rows_eff) begin
			raster_row = 0;
		end
		if (raster_col >= PANEL_COLS) begin
			raster_col = 0;
		end
		beat.pixel_color = pixel_colour(raster_row, raster_col);
		beat.band_last   = (raster_col == PANEL_COLS - 1 && raster_row == rows_eff - 1);
		expected_pixels.push_back(beat);
		if (raster_col == PANEL_COLS - 1) begin
			raster_col = 0;
			raster_row = beat.band_last ? 0 : raster_row + 1;
		end else begin
			raster_col++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_scale  = 3'd3;
			band_rows  = 8'd36;
			text_chars = 6'd0;
			tone       = 3'd0;
			raster_row = 0;
			raster_col = 0;
			for (int i = 0; i < BUF_SLOTS; i++) begin
				line_chars[i] = 8'h00;
			end
			expected_pixels.delete();
			pending = 0;
		end else begin
			// Track register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					trpg_pkg::CFG_GLYPH_SCALE: dot_scale  = cfg_data[2:0];
					trpg_pkg::CFG_BAND_HEIGHT: band_rows  = cfg_data;
					trpg_pkg::CFG_TEXT_LENGTH: text_chars = cfg_data[5:0];
					trpg_pkg::CFG_ROW_TONE:    tone       = cfg_data[2:0];
					default: ;
				endcase
			end
			// Store a character or predict a pixel for each input beat
			if (in_valid && in_ready) begin
				if (in_data.kind == trpg_pkg::KIND_LOAD) begin
					line_chars[in_data.char_position] = in_data.char_code;
				end else begin
					predict_tick();
				end
			end
			// Compare each output beat against the oldest prediction
			if (out_valid && out_ready) begin
				if (expected_pixels.size() == 0) begin
					$error("pixel beat with none outstanding: pixel_color %h band_last %b",
						out_data.pixel_color, out_data.band_last);
					fail_count++;
				end else begin
					want = expected_pixels.pop_front();
					if (out_data.pixel_color !== want.pixel_color) begin
						$error("pixel_color: expected %h, actual %h",
							want.pixel_color, out_data.pixel_color);
						fail_count++;
					end
					if (out_data.band_last !== want.band_last) begin
						$error("band_last: expected %b, actual %b",
							want.band_last, out_data.band_last);
						fail_count++;
					end
				end
			end
			pending = expected_pixels.size();
		end
	end

endmodule

// ===== test/text_row_pixel_generator_tb.sv =====
`timescale 1ns / 100ps

module text_row_pixel_generator_tb;

	localparam int PANEL_COLS  = 128;
	localparam int BUF_SLOTS   = 32;
	localparam int GLYPHS      = 48;
	localparam int CYCLE_LIMIT = 150000;
	localparam int SETTLE      = 6;
	localparam int IDLE_PCT    = 29;
	localparam int PHASES      = 8;
	localparam int LONG_PHASE  = 3;

	localparam logic [8*GLYPHS-1:0] GLYPH_SET =
		" -.0123456789:?ABCDEFGHIJKLMNOPQRSTUVWXYZbdkmpsz";

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       in_valid  = 1'b0;
	logic                       in_ready;
	trpg_pkg::in_item_t         in_data   = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	trpg_pkg::out_item_t        out_data;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [1:0]                 cfg_index = 2'd0;
	logic [trpg_pkg::CFG_W-1:0] cfg_data  = '0;

	int                  pixel_fails;
	int                  pixels_due;
	int                  cycle_count = 0;
	logic                quiet = 1'b0;
	logic [BUF_SLOTS-1:0] slot_written = '0;

	logic [2:0]          pick_scale;
	logic [7:0]          pick_height;
	logic [5:0]          pick_len;
	logic [2:0]          pick_tone;
	int                  n_items;
	int                  tick_share;

	text_row_pixel_generator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	text_row_pixel_checker pixel_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (pixel_fails),
		.pending    (pixels_due)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a run that hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Stall the output side at random, never during the quiet stretch
	always @(negedge clk) begin
		out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// Mostly font characters, the rest any byte
	function automatic logic [7:0] random_code();
		int k;
		k = $urandom_range(0, GLYPHS - 1);
		if ($urandom_range(0, 99) < 70) begin
			return GLYPH_SET[8*k +: 8];
		end
		return 8'($urandom());
	endfunction

	// Slots that the raster can read under a given scale and text length
	function automatic int slots_read(logic [2:0] s, logic [5:0] n);
		int sc, left, shown, len;
		sc    = (s == 0) ? 1 : s;
		left  = (sc == 3) ? 1 : 2;
		shown = (PANEL_COLS - 1 - left) / (6 * sc) + 1;
		len   = (n > BUF_SLOTS) ? BUF_SLOTS : n;
		return (len < shown) ? len : shown;
	endfunction

	// Present one input beat, with random gaps, and hold it until taken
	task automatic send_beat(trpg_pkg::in_item_t beat);
		@(negedge clk);
		while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= beat;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
	endtask

	task automatic load_char(logic [4:0] pos, logic [7:0] code);
		trpg_pkg::in_item_t beat;
		beat.kind          = trpg_pkg::KIND_LOAD;
		beat.char_position = pos;
		beat.char_code     = code;
		slot_written[pos]  = 1'b1;
		send_beat(beat);
	endtask

	// Unused fields of a tick carry noise
	task automatic send_tick();
		trpg_pkg::in_item_t beat;
		beat.kind          = trpg_pkg::KIND_TICK;
		beat.char_position = 5'($urandom());
		beat.char_code     = 8'($urandom());
		send_beat(beat);
	endtask

	// Drop valid and wait for every pixel to drain
	task automatic wait_quiet();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pixels_due != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(trpg_pkg::cfg_index_t idx, logic [trpg_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_regs(logic [2:0] s, logic [7:0] h, logic [5:0] n, logic [2:0] t);
		write_reg(trpg_pkg::CFG_GLYPH_SCALE, trpg_pkg::CFG_W'(s));
		write_reg(trpg_pkg::CFG_BAND_HEIGHT, h);
		write_reg(trpg_pkg::CFG_TEXT_LENGTH, trpg_pkg::CFG_W'(n));
		write_reg(trpg_pkg::CFG_ROW_TONE, trpg_pkg::CFG_W'(t));
	endtask

	// Write every slot the raster may read that still holds nothing
	task automatic fill_slots(int upto);
		for (int i = 0; i < upto; i++) begin
			if (!slot_written[i]) begin
				load_char(5'(i), random_code());
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: short band at scale 1, unknown codes, slot extremes
		set_regs(3'd1, 8'd1, 6'd4, 3'd1);
		load_char(5'd0, 8'h00);
		load_char(5'd1, 8'hFF);
		load_char(5'd2, "A");
		load_char(5'd3, "z");
		load_char(5'd31, "M");
		repeat (8) send_tick();

		// Scale zero, height zero, text past the buffer, spare tone
		wait_quiet();
		set_regs(3'd0, 8'd0, 6'd63, 3'd7);
		repeat (6) send_tick();

		// Largest scale and tallest band
		wait_quiet();
		set_regs(3'd7, 8'd255, 6'd32, 3'd5);
		load_char(5'd4, "-");
		load_char(5'd5, ".");
		repeat (4) send_tick();

		// Random phases; one long quiet phase on a one-row band sees the band end
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_quiet();
			pick_scale = 3'($urandom_range(0, 7));
			case ($urandom_range(0, 5))
				0:       pick_height = 8'd0;
				1:       pick_height = 8'd255;
				2:       pick_height = 8'($urandom_range(1, 255));
				default: pick_height = 8'($urandom_range(1, 8));
			endcase
			pick_len  = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(33, 63))
			                                        : 6'($urandom_range(0, 32));
			pick_tone = 3'($urandom_range(0, 7));
			if (ph == 0) begin
				pick_len  = 6'd0;
				pick_tone = 3'd0;
			end
			if (ph == LONG_PHASE) begin
				pick_height = 8'd1;
			end
			set_regs(pick_scale, pick_height, pick_len, pick_tone);
			quiet = (ph == LONG_PHASE);
			fill_slots(slots_read(pick_scale, pick_len));
			n_items    = (ph == LONG_PHASE) ? 200 : 30;
			tick_share = (ph == LONG_PHASE) ? 95 : 75;
			for (int k = 0; k < n_items; k++) begin
				// Hold off the sender once per phase until all pixels are out
				if (k == n_items / 2) begin
					wait_quiet();
				end
				if ($urandom_range(0, 99) < tick_share) begin
					send_tick();
				end else begin
					load_char(5'($urandom()), random_code());
				end
			end
			quiet = 1'b0;
		end

		wait_quiet();
		if (pixel_fails == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
design/trpg_pkg.sv
design/trpg_ram.sv
design/trpg_ctrl.sv
design/trpg_datapath.sv
design/text_row_pixel_generator.sv
design/trpg_checker.sv
test/text_row_pixel_checker.sv
test/text_row_pixel_generator_tb.sv
